// File: design/hft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hft_pkg
// Shared types and constants of the HPACK field block tokenizer.
// ----------------------------------------------------------------------------
package hft_pkg;

  typedef enum logic [2:0] {
    EV_INDEXED = 3'd0,
    EV_LITERAL = 3'd1,
    EV_LENGTH  = 3'd2,
    EV_BYTE    = 3'd3,
    EV_SIZE    = 3'd4,
    EV_DONE    = 3'd5,
    EV_ERROR   = 3'd6
  } event_kind_t;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_SHORT_BLOCK     = 2'd1,
    ST_INT_OVERFLOW    = 2'd2,
    ST_BAD_SIZE_UPDATE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_LEN_START = 2'd1,
    PH_INTEGER   = 2'd2,
    PH_STRING    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    PU_INDEX      = 2'd0,
    PU_NAME_INDEX = 2'd1,
    PU_LENGTH     = 2'd2,
    PU_SIZE       = 2'd3
  } purpose_t;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] value;
    logic        huffman_coded;
    logic        is_value_string;
    logic        add_to_table;
    status_t     status;
    logic        last;
  } event_t;

  typedef struct packed {
    logic [1:0] count;
    event_t     first;
    event_t     second;
  } push_t;

  localparam logic [31:0] ALLOWED_SIZE_RESET = 32'd4096;

  localparam logic [4:0] MAX_SHIFT   = 5'd28;
  localparam logic [4:0] SHIFT_STEP  = 5'd7;
  localparam logic [6:0] CHUNK_LIMIT = 7'h0f;

  localparam logic [6:0] MASK_7 = 7'h7f;
  localparam logic [6:0] MASK_6 = 7'h3f;
  localparam logic [6:0] MASK_5 = 7'h1f;
  localparam logic [6:0] MASK_4 = 7'h0f;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;
  localparam int OUTQ_CW    = 3;

  function automatic event_t make_event(event_kind_t kind, logic [31:0] value,
                                        logic huf, logic isval, logic add,
                                        status_t st);
    event_t e;
    e.kind            = kind;
    e.value           = value;
    e.huffman_coded   = huf;
    e.is_value_string = isval;
    e.add_to_table    = add;
    e.status          = st;
    e.last            = 1'b0;
    return e;
  endfunction

endpackage
`default_nettype wire

// File: design/hft_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hft_parse
// Parse state and the per-byte step: classifies representations, decodes
// prefix integers and produces up to two result items per byte.
// ----------------------------------------------------------------------------
module hft_parse
  import hft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  in_byte,
  input  logic        in_end,
  input  logic [31:0] allowed_table_size,
  output push_t       push
);

  phase_t      phase, phase_next;
  logic [31:0] int_sum, int_sum_next;
  logic [4:0]  int_shift, int_shift_next;
  purpose_t    purpose, purpose_next;
  logic [31:0] str_left, str_left_next;
  logic        str_is_value, str_is_value_next;
  logic        lit_indexes, lit_indexes_next;
  logic        str_huffman, str_huffman_next;
  logic        header_seen, header_seen_next;
  logic        discard, discard_next;

  logic [31:0] addend;
  logic [32:0] sum_ext;
  logic        begin_go;
  logic [6:0]  pv;
  logic [6:0]  pmask;
  logic        fin_go;
  logic [31:0] fin_sum;
  logic        str_done;
  logic        do_fail;
  status_t     fail_st;
  logic        do_clear;
  logic [1:0]  n_ev;
  event_t      ev0, ev1;

  assign addend  = 32'({25'd0, in_byte[6:0]} << int_shift);
  assign sum_ext = {1'b0, int_sum} + {1'b0, addend};

  always_comb begin
    phase_next        = phase;
    int_sum_next      = int_sum;
    int_shift_next    = int_shift;
    purpose_next      = purpose;
    str_left_next     = str_left;
    str_is_value_next = str_is_value;
    lit_indexes_next  = lit_indexes;
    str_huffman_next  = str_huffman;
    header_seen_next  = header_seen;
    discard_next      = discard;
    begin_go          = 1'b0;
    pv                = '0;
    pmask             = '0;
    fin_go            = 1'b0;
    fin_sum           = '0;
    str_done          = 1'b0;
    do_fail           = 1'b0;
    fail_st           = ST_OK;
    do_clear          = 1'b0;
    n_ev              = 2'd0;
    ev0               = make_event(EV_INDEXED, '0, 1'b0, 1'b0, 1'b0, ST_OK);
    ev1               = ev0;

    if (fire) begin
      if (discard) begin
        if (in_end) begin
          discard_next     = 1'b0;
          header_seen_next = 1'b0;
          do_clear         = 1'b1;
        end
      end else begin
        unique case (phase)
          PH_LEN_START: begin
            str_huffman_next = in_byte[7];
            purpose_next     = PU_LENGTH;
            begin_go         = 1'b1;
            pv               = in_byte[6:0];
            pmask            = MASK_7;
          end
          PH_INTEGER: begin
            if (int_shift >= MAX_SHIFT && in_byte[6:0] > CHUNK_LIMIT) begin
              do_fail = 1'b1;
              fail_st = ST_INT_OVERFLOW;
            end else if (sum_ext[32]) begin
              do_fail = 1'b1;
              fail_st = ST_INT_OVERFLOW;
            end else begin
              int_sum_next = sum_ext[31:0];
              if (!in_byte[7]) begin
                fin_go  = 1'b1;
                fin_sum = sum_ext[31:0];
              end else if (int_shift > MAX_SHIFT - SHIFT_STEP) begin
                do_fail = 1'b1;
                fail_st = ST_INT_OVERFLOW;
              end else begin
                int_shift_next = int_shift + SHIFT_STEP;
              end
            end
          end
          PH_STRING: begin
            ev0           = make_event(EV_BYTE, {24'd0, in_byte}, 1'b0, str_is_value,
                                       1'b0, ST_OK);
            n_ev          = 2'd1;
            str_left_next = str_left - 32'd1;
            if (str_left_next == 32'd0) begin
              str_done = 1'b1;
            end
          end
          PH_IDLE: begin
            if (in_byte[7]) begin
              header_seen_next = 1'b1;
              purpose_next     = PU_INDEX;
              begin_go         = 1'b1;
              pv               = in_byte[6:0];
              pmask            = MASK_7;
            end else if (in_byte[6]) begin
              header_seen_next  = 1'b1;
              lit_indexes_next  = 1'b1;
              str_is_value_next = 1'b0;
              purpose_next      = PU_NAME_INDEX;
              begin_go          = 1'b1;
              pv                = {1'b0, in_byte[5:0]};
              pmask             = MASK_6;
            end else if (in_byte[5]) begin
              if (header_seen) begin
                do_fail = 1'b1;
                fail_st = ST_BAD_SIZE_UPDATE;
              end else begin
                purpose_next = PU_SIZE;
                begin_go     = 1'b1;
                pv           = {2'd0, in_byte[4:0]};
                pmask        = MASK_5;
              end
            end else begin
              header_seen_next  = 1'b1;
              lit_indexes_next  = 1'b0;
              str_is_value_next = 1'b0;
              purpose_next      = PU_NAME_INDEX;
              begin_go          = 1'b1;
              pv                = {3'd0, in_byte[3:0]};
              pmask             = MASK_4;
            end
          end
        endcase

        if (begin_go) begin
          if (pv != pmask) begin
            fin_go  = 1'b1;
            fin_sum = {25'd0, pv};
          end else begin
            int_sum_next   = {25'd0, pmask};
            int_shift_next = '0;
            phase_next     = PH_INTEGER;
          end
        end

        if (fin_go) begin
          unique case (purpose_next)
            PU_INDEX: begin
              ev0        = make_event(EV_INDEXED, fin_sum, 1'b0, 1'b0, 1'b0, ST_OK);
              n_ev       = 2'd1;
              phase_next = PH_IDLE;
            end
            PU_NAME_INDEX: begin
              ev0               = make_event(EV_LITERAL, fin_sum, 1'b0, 1'b0,
                                             lit_indexes_next, ST_OK);
              n_ev              = 2'd1;
              str_is_value_next = (fin_sum != 32'd0);
              phase_next        = PH_LEN_START;
            end
            PU_LENGTH: begin
              ev0  = make_event(EV_LENGTH, fin_sum, str_huffman_next, str_is_value_next,
                                1'b0, ST_OK);
              n_ev = 2'd1;
              if (fin_sum == 32'd0) begin
                str_done = 1'b1;
              end else begin
                str_left_next = fin_sum;
                phase_next    = PH_STRING;
              end
            end
            PU_SIZE: begin
              if (fin_sum > allowed_table_size) begin
                do_fail = 1'b1;
                fail_st = ST_BAD_SIZE_UPDATE;
              end else begin
                ev0        = make_event(EV_SIZE, fin_sum, 1'b0, 1'b0, 1'b0, ST_OK);
                n_ev       = 2'd1;
                phase_next = PH_IDLE;
              end
            end
          endcase
        end

        if (str_done) begin
          if (!str_is_value_next) begin
            str_is_value_next = 1'b1;
            phase_next        = PH_LEN_START;
          end else begin
            phase_next = PH_IDLE;
          end
        end

        if (do_fail) begin
          ev0          = make_event(EV_ERROR, '0, 1'b0, 1'b0, 1'b0, fail_st);
          n_ev         = 2'd1;
          phase_next   = PH_IDLE;
          discard_next = 1'b1;
          do_clear     = 1'b1;
        end

        if (in_end) begin
          if (do_fail) begin
            discard_next = 1'b0;
          end else if (phase_next == PH_IDLE) begin
            if (n_ev == 2'd0) begin
              ev0 = make_event(EV_DONE, '0, 1'b0, 1'b0, 1'b0, ST_OK);
            end else begin
              ev1 = make_event(EV_DONE, '0, 1'b0, 1'b0, 1'b0, ST_OK);
            end
            n_ev = n_ev + 2'd1;
          end else begin
            if (n_ev == 2'd0) begin
              ev0 = make_event(EV_ERROR, '0, 1'b0, 1'b0, 1'b0, ST_SHORT_BLOCK);
            end else begin
              ev1 = make_event(EV_ERROR, '0, 1'b0, 1'b0, 1'b0, ST_SHORT_BLOCK);
            end
            n_ev = n_ev + 2'd1;
          end
          header_seen_next = 1'b0;
          do_clear         = 1'b1;
        end
      end

      if (do_clear) begin
        phase_next        = PH_IDLE;
        int_sum_next      = '0;
        int_shift_next    = '0;
        purpose_next      = PU_INDEX;
        str_left_next     = '0;
        str_is_value_next = 1'b0;
        lit_indexes_next  = 1'b0;
        str_huffman_next  = 1'b0;
      end
    end

    if (n_ev == 2'd1) begin
      ev0.last = 1'b1;
    end else if (n_ev == 2'd2) begin
      ev1.last = 1'b1;
    end

    push.count  = n_ev;
    push.first  = ev0;
    push.second = ev1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      int_sum      <= '0;
      int_shift    <= '0;
      purpose      <= PU_INDEX;
      str_left     <= '0;
      str_is_value <= 1'b0;
      lit_indexes  <= 1'b0;
      str_huffman  <= 1'b0;
      header_seen  <= 1'b0;
      discard      <= 1'b0;
    end else begin
      phase        <= phase_next;
      int_sum      <= int_sum_next;
      int_shift    <= int_shift_next;
      purpose      <= purpose_next;
      str_left     <= str_left_next;
      str_is_value <= str_is_value_next;
      lit_indexes  <= lit_indexes_next;
      str_huffman  <= str_huffman_next;
      header_seen  <= header_seen_next;
      discard      <= discard_next;
    end
  end

endmodule
`default_nettype wire

// File: design/hft_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hft_outq
// Result queue: takes up to two items per cycle, hands out one per cycle while pop_ready is high.
// ----------------------------------------------------------------------------
module hft_outq
  import hft_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  push_t  push,
  input  logic   pop_ready,
  output event_t head,
  output logic   head_valid,
  output logic   space
);

  event_t               mem [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr;
  logic [OUTQ_AW-1:0]   rd_ptr;
  logic [OUTQ_CW-1:0]   count;
  logic                 pop;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && pop_ready;
  assign space      = (count <= OUTQ_CW'(OUTQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + OUTQ_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_AW'(push.count);
      rd_ptr <= rd_ptr + OUTQ_AW'(pop);
      count  <= count + OUTQ_CW'(push.count) - OUTQ_CW'(pop);
    end
  end

endmodule
`default_nettype wire

// File: design/hpack_field_block_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpack_field_block_tokenizer
// HPACK field block tokenizer: prefix integers, string lengths and bytes,
// size updates, block done and error items.
// ----------------------------------------------------------------------------
// The block takes one byte of a field block per cycle while the result queue
// has space, and gives the items it causes through an input register, then a
// four-entry result queue. Most bytes cause at most one item; the final byte
// of a block causes up to two (its own item plus block done or a short-block
// error). The queue drains one item per cycle while the sink is ready, so with
// the sink always ready the sustained rate is one byte per cycle, apart from
// stalls when the extra items of block ends fill the queue. Items come out on
// m_axis with tlast on the last item of each byte; after an error the rest of
// the block is dropped without items.
module hpack_field_block_tokenizer
  import hft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] value, [32] huffman_coded,
                                      // [33] is_value_string, [34] add_to_table,
                                      // [36:35] status, [39:37] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  output logic        m_axis_tlast
);

  logic [31:0] allowed_table_size;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_end;
  logic        space;
  logic        fire;
  push_t       push;
  event_t      head;

  assign fire          = in_valid && space;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed_table_size <= ALLOWED_SIZE_RESET;
    end else if (cfg_wr_en) begin
      allowed_table_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_end  <= s_axis_tlast;
    end
  end

  hft_parse u_parse (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .in_byte            (in_byte),
    .in_end             (in_end),
    .allowed_table_size (allowed_table_size),
    .push               (push)
  );

  hft_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop_ready  (m_axis_tready),
    .head       (head),
    .head_valid (m_axis_tvalid),
    .space      (space)
  );

  assign m_axis_tdata = {3'd0, head.status, head.add_to_table, head.is_value_string,
                         head.huffman_coded, head.value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

// File: design/hft_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hft_port_checks
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module hft_port_checks
  import hft_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result item present right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result item changed");

  a_end_items_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == EV_DONE || m_axis_tuser == EV_ERROR) |->
      m_axis_tlast && m_axis_tdata[31:0] == 32'd0)
    else $error("done or error item not last of its byte or carries a value");

  a_status_only_on_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != EV_ERROR |-> m_axis_tdata[36:35] == 2'd0)
    else $error("nonzero status on a non-error item");

endmodule

bind hpack_field_block_tokenizer hft_port_checks u_hft_port_checks (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: tb/sv/hft_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hft_checker
// Watches the byte and item channels of the HPACK field block tokenizer,
// works out the items each accepted byte must give, and compares every item
// that leaves the block with the oldest one still expected.
// ----------------------------------------------------------------------------
module hft_checker
  import hft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [31:0] value, [32] huffman_coded,
                                      // [33] is_value_string, [34] add_to_table,
                                      // [36:35] status, [39:37] zero
  input  logic [2:0]  m_axis_tuser,   // [2:0] event_kind
  input  logic        m_axis_tlast,
  output int          mismatch_count,
  output int          items_outstanding
);

  logic [31:0] size_limit;
  phase_t      phase;
  purpose_t    purpose;
  logic [31:0] int_sum;
  logic [4:0]  int_shift;
  logic [31:0] str_left;
  logic        str_is_value;
  logic        str_huffman;
  logic        lit_indexes;
  logic        hdr_seen;
  logic        discarding;
  logic        byte_failed;
  event_t      byte_items[$];
  event_t      expected_items[$];
  int          mismatches = 0;

  function automatic string item_text(event_t e);
    return $sformatf("kind %0d value %h huffman %b value_string %b add %b status %0d last %b",
                     e.kind, e.value, e.huffman_coded, e.is_value_string,
                     e.add_to_table, e.status, e.last);
  endfunction

  function automatic void add_item(event_kind_t kind, logic [31:0] value, logic huf,
                                   logic isval, logic add, status_t st);
    event_t e;
    e.kind            = kind;
    e.value           = value;
    e.huffman_coded   = huf;
    e.is_value_string = isval;
    e.add_to_table    = add;
    e.status          = st;
    e.last            = 1'b0;
    byte_items.push_back(e);
  endfunction

  function automatic void clear_parse();
    phase        = PH_IDLE;
    purpose      = PU_INDEX;
    int_sum      = '0;
    int_shift    = '0;
    str_left     = '0;
    str_is_value = 1'b0;
    str_huffman  = 1'b0;
    lit_indexes  = 1'b0;
  endfunction

  function automatic void raise_error(status_t st);
    add_item(EV_ERROR, '0, 1'b0, 1'b0, 1'b0, st);
    clear_parse();
    discarding  = 1'b1;
    byte_failed = 1'b1;
  endfunction

  function automatic void close_string();
    if (!str_is_value) begin
      str_is_value = 1'b1;
      phase        = PH_LEN_START;
    end else begin
      phase = PH_IDLE;
    end
  endfunction

  function automatic void complete_integer(logic [31:0] sum);
    case (purpose)
      PU_INDEX: begin
        add_item(EV_INDEXED, sum, 1'b0, 1'b0, 1'b0, ST_OK);
        phase = PH_IDLE;
      end
      PU_NAME_INDEX: begin
        add_item(EV_LITERAL, sum, 1'b0, 1'b0, lit_indexes, ST_OK);
        str_is_value = (sum != '0);
        phase        = PH_LEN_START;
      end
      PU_LENGTH: begin
        add_item(EV_LENGTH, sum, str_huffman, str_is_value, 1'b0, ST_OK);
        if (sum == '0) begin
          close_string();
        end else begin
          str_left = sum;
          phase    = PH_STRING;
        end
      end
      default: begin
        if (sum > size_limit) begin
          raise_error(ST_BAD_SIZE_UPDATE);
        end else begin
          add_item(EV_SIZE, sum, 1'b0, 1'b0, 1'b0, ST_OK);
          phase = PH_IDLE;
        end
      end
    endcase
  endfunction

  function automatic void start_integer(logic [6:0] prefix, logic [6:0] mask, purpose_t p);
    purpose = p;
    if (prefix < mask) begin
      complete_integer({25'd0, prefix});
    end else begin
      int_sum   = {25'd0, mask};
      int_shift = '0;
      phase     = PH_INTEGER;
    end
  endfunction

  function automatic void tokenize_byte(logic [7:0] b, logic eob);
    logic [31:0] addend;
    byte_items.delete();
    byte_failed = 1'b0;
    if (discarding) begin
      if (eob) begin
        discarding = 1'b0;
        clear_parse();
        hdr_seen = 1'b0;
      end
      return;
    end
    case (phase)
      PH_LEN_START: begin
        str_huffman = b[7];
        start_integer(b[6:0], MASK_7, PU_LENGTH);
      end
      PH_INTEGER: begin
        addend = 32'(b[6:0]) << int_shift;
        if (int_shift >= MAX_SHIFT && b[6:0] > CHUNK_LIMIT) begin
          raise_error(ST_INT_OVERFLOW);
        end else if (int_sum > 32'hFFFF_FFFF - addend) begin
          raise_error(ST_INT_OVERFLOW);
        end else begin
          int_sum = int_sum + addend;
          if (!b[7]) begin
            complete_integer(int_sum);
          end else if (int_shift >= MAX_SHIFT) begin
            raise_error(ST_INT_OVERFLOW);
          end else begin
            int_shift = int_shift + SHIFT_STEP;
          end
        end
      end
      PH_STRING: begin
        add_item(EV_BYTE, {24'd0, b}, 1'b0, str_is_value, 1'b0, ST_OK);
        str_left = str_left - 32'd1;
        if (str_left == '0) close_string();
      end
      default: begin
        if (b[7]) begin
          hdr_seen = 1'b1;
          start_integer(b[6:0], MASK_7, PU_INDEX);
        end else if (b[6]) begin
          hdr_seen     = 1'b1;
          lit_indexes  = 1'b1;
          str_is_value = 1'b0;
          start_integer({1'b0, b[5:0]}, MASK_6, PU_NAME_INDEX);
        end else if (b[5]) begin
          if (hdr_seen) raise_error(ST_BAD_SIZE_UPDATE);
          else start_integer({2'b0, b[4:0]}, MASK_5, PU_SIZE);
        end else begin
          hdr_seen     = 1'b1;
          lit_indexes  = 1'b0;
          str_is_value = 1'b0;
          start_integer({3'b0, b[3:0]}, MASK_4, PU_NAME_INDEX);
        end
      end
    endcase
    if (eob) begin
      if (byte_failed) discarding = 1'b0;
      else if (phase == PH_IDLE) add_item(EV_DONE, '0, 1'b0, 1'b0, 1'b0, ST_OK);
      else add_item(EV_ERROR, '0, 1'b0, 1'b0, 1'b0, ST_SHORT_BLOCK);
      clear_parse();
      hdr_seen = 1'b0;
    end
    if (byte_items.size() > 0) byte_items[byte_items.size() - 1].last = 1'b1;
    foreach (byte_items[i]) expected_items.push_back(byte_items[i]);
  endfunction

  always @(posedge clk) begin
    event_t got;
    if (rst) begin
      size_limit = ALLOWED_SIZE_RESET;
      clear_parse();
      hdr_seen   = 1'b0;
      discarding = 1'b0;
      expected_items.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind            = event_kind_t'(m_axis_tuser);
        got.value           = m_axis_tdata[31:0];
        got.huffman_coded   = m_axis_tdata[32];
        got.is_value_string = m_axis_tdata[33];
        got.add_to_table    = m_axis_tdata[34];
        got.status          = status_t'(m_axis_tdata[36:35]);
        got.last            = m_axis_tlast;
        if (expected_items.size() == 0) begin
          if (mismatches < 10) $display("%0t unexpected item: %s", $realtime, item_text(got));
          mismatches++;
        end else begin
          if (got !== expected_items[0]) begin
            if (mismatches < 10) begin
              $display("%0t item mismatch\n  expected %s\n  actual   %s", $realtime,
                       item_text(expected_items[0]), item_text(got));
            end
            mismatches++;
          end
          void'(expected_items.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) tokenize_byte(s_axis_tdata, s_axis_tlast);
      if (cfg_wr_en) size_limit = cfg_wr_data;
    end
    mismatch_count    <= mismatches;
    items_outstanding <= expected_items.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives HPACK field blocks into the tokenizer: a directed set of blocks for
// the edge cases, then random well-formed, truncated, noisy, overflowing and
// late-size-update blocks under four size limits and three handshake idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import hft_pkg::*;

  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int SETTLE_CYCLES     = 8;
  localparam int ITEMS_PER_SETTING = 450;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [31:0] cfg_wr_data   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          mismatch_count;
  int          items_outstanding;
  int          send_idle_pct = 28;
  int          recv_idle_pct = 85;
  int          bytes_sent;
  logic [31:0] table_limit   = ALLOWED_SIZE_RESET;
  logic [7:0]  block_bytes[$];

  always #5 clk = ~clk;

  hpack_field_block_tokenizer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hft_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tlast      (s_axis_tlast),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .m_axis_tlast      (m_axis_tlast),
    .mismatch_count    (mismatch_count),
    .items_outstanding (items_outstanding)
  );

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] pick_number();
    int r = $urandom_range(99);
    if (r < 60) return $urandom_range(10);
    if (r < 85) return $urandom_range(200);
    if (r < 94) return $urandom_range(70000);
    if (r < 97) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(3);
  endfunction

  function automatic logic [31:0] pick_size();
    int r = $urandom_range(99);
    if (r < 20 || (r >= 90 && table_limit == 32'hFFFF_FFFF)) return table_limit;
    if (r < 40) return $urandom_range(40);
    if (r < 90) return 32'(64'($urandom) % (64'(table_limit) + 64'd1));
    return table_limit + 32'd1 + 32'($urandom_range(1000));
  endfunction

  function automatic void put_int(logic [31:0] v, int nbits, logic [7:0] flags);
    logic [31:0] mask;
    logic [31:0] rest;
    mask = (32'd1 << nbits) - 32'd1;
    if (v < mask) begin
      block_bytes.push_back(flags | v[7:0]);
    end else begin
      block_bytes.push_back(flags | mask[7:0]);
      rest = v - mask;
      while (rest >= 32'd128) begin
        block_bytes.push_back({1'b1, rest[6:0]});
        rest = rest >> 7;
      end
      block_bytes.push_back({1'b0, rest[6:0]});
    end
  endfunction

  function automatic void put_text();
    int len = ($urandom_range(99) < 5) ? $urandom_range(100, 200) : $urandom_range(8);
    put_int(len, 7, {1'($urandom_range(1)), 7'd0});
    repeat (len) block_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void put_field();
    int          kind = $urandom_range(3);
    logic [31:0] name_idx;
    if (kind == 0) begin
      put_int(pick_number(), 7, 8'h80);
      return;
    end
    name_idx = ($urandom_range(99) < 40) ? 32'd0 : pick_number();
    case (kind)
      1:       put_int(name_idx, 6, 8'h40);
      2:       put_int(name_idx, 4, 8'h00);
      default: put_int(name_idx, 4, 8'h10);
    endcase
    if (name_idx == '0) put_text();
    put_text();
  endfunction

  function automatic void put_block();
    repeat (($urandom_range(99) < 30) ? $urandom_range(1, 2) : 0) put_int(pick_size(), 5, 8'h20);
    repeat ($urandom_range(1, 4)) put_field();
  endfunction

  task automatic send_block();
    foreach (block_bytes[i]) begin
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= block_bytes[i];
      s_axis_tlast  <= (i == block_bytes.size() - 1);
      do @(posedge clk); while (!s_axis_tready);
    end
    bytes_sent += block_bytes.size();
    block_bytes.delete();
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (items_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    table_limit = v;
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int seg;
    int pick;
    int cut;
    int tail_kind;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // size updates at both ends of the limit, index zero, largest index
    put_int(0, 5, 8'h20);
    put_int(table_limit, 5, 8'h20);
    put_int(0, 7, 8'h80);
    put_int(32'hFFFF_FFFF, 7, 8'h80);
    send_block();
    // literal name with Huffman flag, empty value; never indexed; full 4-bit prefix
    block_bytes = '{8'h40, 8'h81, 8'h61, 8'h00, 8'h15, 8'h01, 8'hFF, 8'h0F, 8'h00, 8'h00};
    send_block();
    // size update after a field: drop the rest of the block
    block_bytes = '{8'h81, 8'h20, 8'h55, 8'h3F};
    send_block();
    // size update above the limit
    put_int(table_limit + 32'd1, 5, 8'h20);
    block_bytes.push_back(8'h00);
    send_block();
    // chunk too large at the last shift
    block_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h1F, 8'hAA};
    send_block();
    // block ends inside a literal, then an error on the final byte
    block_bytes = '{8'h40};
    send_block();
    block_bytes = '{8'h81, 8'h20};
    send_block();

    for (seg = 0; seg < 4; seg++) begin
      case (seg)
        1: write_limit(32'd0);
        2: begin
          send_idle_pct = 85;
          recv_idle_pct = 28;
          write_limit(32'hFFFF_FFFF);
        end
        3: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_limit($urandom_range(1, 100000));
        end
        default: ;
      endcase
      bytes_sent = 0;
      while (bytes_sent < ITEMS_PER_SETTING) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          put_block();
        end else if (pick < 82) begin
          if ($urandom_range(1)) begin
            put_block();
          end else begin
            block_bytes.push_back(8'h40);
            put_int($urandom, 7, {1'($urandom_range(1)), 7'd0});
            repeat (3) block_bytes.push_back(8'($urandom_range(255)));
          end
          cut = $urandom_range(1, block_bytes.size());
          while (block_bytes.size() > cut) void'(block_bytes.pop_back());
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 8)) block_bytes.push_back(8'($urandom_range(255)));
        end else if (pick < 95) begin
          put_field();
          put_int(pick_size(), 5, 8'h20);
          put_field();
        end else begin
          tail_kind = $urandom_range(2);
          case ($urandom_range(3))
            0:       block_bytes.push_back(8'hFF);
            1:       block_bytes.push_back(8'h7F);
            2:       block_bytes.push_back(8'h0F);
            default: block_bytes.push_back(8'h3F);
          endcase
          repeat (4) begin
            block_bytes.push_back((tail_kind == 1) ? 8'hFF : {1'b1, 7'($urandom_range(127))});
          end
          case (tail_kind)
            0:       block_bytes.push_back({1'($urandom_range(1)), 7'($urandom_range(16, 127))});
            1:       block_bytes.push_back(8'h0F);
            default: block_bytes.push_back({4'b1000, 4'($urandom_range(15))});
          endcase
          repeat ($urandom_range(3)) block_bytes.push_back(8'($urandom_range(255)));
        end
        send_block();
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (items_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
